[sv/gilp_pkg.sv]
`default_nettype none
package gilp_pkg;

  localparam int unsigned PrefixLen = 10;
  localparam int unsigned StampLen  = 14;
  localparam int unsigned LenMax    = 31;
  localparam int unsigned Fields    = 5;

  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChNul   = 8'h00;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_PREFIX  = 3'd1,
    ST_MISSING = 3'd2,
    ST_LONG    = 3'd3,
    ST_CHAR    = 3'd4,
    ST_STAMP   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    KIND_SUM = 2'd0,
    KIND_LAT = 2'd1,
    KIND_LON = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_ZERO  = 2'd1,
    CLS_ONE   = 2'd2,
    CLS_OTHER = 2'd3
  } cls_e;

  localparam logic [2:0] FieldPower = 3'd0;
  localparam logic [2:0] FieldFix   = 3'd1;
  localparam logic [2:0] FieldStamp = 3'd2;
  localparam logic [2:0] FieldLat   = 3'd3;
  localparam logic [2:0] FieldLon   = 3'd4;
  localparam logic [2:0] FieldPast  = 3'd5;

  typedef struct packed {
    logic [3:0]         prefix_matched;
    logic               prefix_bad;
    logic [7:0]         byte_count;
    logic               cut;
    logic [2:0]         field_number;
    logic [4:0]         field_length;
    logic               field_over;
    cls_e               power_value;
    cls_e               fix_value;
    logic [55:0]        stamp_digits;
    logic               stamp_bad;
    status_e [Fields-1:0] field_code;
  } line_state_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  text_char;
    logic        power_on;
    logic        has_fix;
    status_e     status;
    logic [31:0] date_digits;
    logic [23:0] time_digits;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic    char_valid;
    result_t char_res;
    logic    sum_valid;
    result_t sum_res;
  } push_t;

  function automatic line_state_t line_clear();
    line_state_t s;
    s = '0;
    for (int i = 0; i < Fields; i++) begin
      s.field_code[i] = ST_MISSING;
    end
    return s;
  endfunction

  function automatic logic [7:0] prefix_byte(logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h2b;
      4'd1:    b = 8'h43;
      4'd2:    b = 8'h47;
      4'd3:    b = 8'h4e;
      4'd4:    b = 8'h53;
      4'd5:    b = 8'h49;
      4'd6:    b = 8'h4e;
      4'd7:    b = 8'h46;
      4'd8:    b = 8'h3a;
      4'd9:    b = 8'h20;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic cls_e classify(logic [7:0] ch);
    cls_e c;
    if (ch == ChZero) c = CLS_ZERO;
    else if (ch == ChOne) c = CLS_ONE;
    else c = CLS_OTHER;
    return c;
  endfunction

  function automatic line_state_t close_field(line_state_t s, logic term,
                                              logic [4:0] fchars);
    status_e    code;
    logic [4:0] fsize;
    fsize = (s.field_number < FieldStamp) ? 5'd2 : fchars;
    if (s.field_over) code = ST_LONG;
    else if (!term) code = ST_MISSING;
    else if (s.field_length >= fsize) code = ST_LONG;
    else if (s.field_number == FieldPower)
      code = (s.power_value == CLS_ZERO || s.power_value == CLS_ONE) ? ST_OK : ST_CHAR;
    else if (s.field_number == FieldFix)
      code = (s.fix_value == CLS_ZERO || s.fix_value == CLS_ONE) ? ST_OK : ST_CHAR;
    else if (s.field_number == FieldStamp)
      code = (s.field_length < 5'(StampLen) || s.stamp_bad) ? ST_STAMP : ST_OK;
    else code = ST_OK;
    if (s.field_number <= FieldLon) begin
      s.field_code[s.field_number] = code;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

[sv/gilp_parser.sv]
`default_nettype none
module gilp_parser #(
  parameter int FIELD_CHARS = 16,
  parameter int MAX_LINE    = 255
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           acc_i,
  input  wire logic [7:0]     ch_i,
  input  wire logic           line_last_i,
  output gilp_pkg::push_t     push_o
);
  import gilp_pkg::*;

  localparam logic [4:0] FieldChars  = 5'(FIELD_CHARS);
  localparam logic [4:0] CoordChars  = 5'(FIELD_CHARS - 1);
  localparam logic [7:0] MaxLine     = 8'(MAX_LINE);

  line_state_t st_q, st_d, fin;
  logic        line_done_q;
  logic        take;
  logic        end_line;
  logic [4:0]  fsize;
  logic [2:0]  n;
  status_e     sum_st;
  logic        sum_p, sum_f;

  always_comb begin
    st_d   = line_done_q ? line_clear() : st_q;
    push_o = '0;
    fin    = '0;
    fsize  = '0;
    sum_st = ST_OK;
    sum_p  = 1'b0;
    sum_f  = 1'b0;
    n      = st_d.field_number;
    take   = !st_d.cut && (st_d.byte_count < MaxLine) && (ch_i != ChNul);
    if (ch_i == ChNul) st_d.cut = 1'b1;

    if (take) begin
      st_d.byte_count = st_d.byte_count + 8'd1;
      if (st_d.prefix_matched < 4'(PrefixLen)) begin
        if (ch_i != prefix_byte(st_d.prefix_matched)) st_d.prefix_bad = 1'b1;
        st_d.prefix_matched = st_d.prefix_matched + 4'd1;
      end else if (!st_d.prefix_bad) begin
        if (ch_i == ChComma || ch_i == ChCr) begin
          st_d = close_field(st_d, 1'b1, FieldChars);
          if (ch_i == ChCr) st_d.field_number = FieldPast;
          else if (st_d.field_number < FieldPast)
            st_d.field_number = st_d.field_number + 3'd1;
          st_d.field_length = '0;
          st_d.field_over   = 1'b0;
        end else if (n <= FieldLon) begin
          fsize = (n < FieldStamp) ? 5'd2 : FieldChars;
          if (st_d.field_length >= fsize) begin
            st_d.field_over = 1'b1;
          end else if (n == FieldPower) begin
            if (st_d.field_length == '0) st_d.power_value = classify(ch_i);
          end else if (n == FieldFix) begin
            if (st_d.field_length == '0) st_d.fix_value = classify(ch_i);
          end else if (n == FieldStamp) begin
            if (st_d.field_length < 5'(StampLen)) begin
              if (ch_i >= ChZero && ch_i <= ChNine)
                st_d.stamp_digits = {st_d.stamp_digits[51:0], ch_i[3:0]};
              else
                st_d.stamp_bad = 1'b1;
            end
          end else begin
            if (st_d.field_code[FieldPower] == ST_OK && st_d.power_value == CLS_ONE &&
                st_d.field_code[FieldFix] == ST_OK && st_d.fix_value == CLS_ONE &&
                st_d.field_length < CoordChars) begin
              push_o.char_valid         = 1'b1;
              push_o.char_res.kind      = (n == FieldLat) ? KIND_LAT : KIND_LON;
              push_o.char_res.text_char = ch_i;
            end
          end
          if (st_d.field_length < 5'(LenMax))
            st_d.field_length = st_d.field_length + 5'd1;
        end
      end
    end

    end_line = line_last_i || (ch_i == ChCr);
    if (end_line) begin
      if (st_d.prefix_bad || st_d.prefix_matched < 4'(PrefixLen) ||
          st_d.byte_count <= 8'(PrefixLen)) begin
        sum_st = ST_PREFIX;
      end else begin
        fin = close_field(st_d, 1'b0, FieldChars);
        if (fin.field_code[FieldPower] != ST_OK) sum_st = fin.field_code[FieldPower];
        else if (fin.power_value == CLS_ONE) begin
          sum_p = 1'b1;
          if (fin.field_code[FieldFix] != ST_OK) sum_st = fin.field_code[FieldFix];
          else if (fin.fix_value == CLS_ONE) begin
            sum_f = 1'b1;
            if (fin.field_code[FieldLat] != ST_OK) sum_st = fin.field_code[FieldLat];
            else if (fin.field_code[FieldLon] != ST_OK) sum_st = fin.field_code[FieldLon];
            else sum_st = fin.field_code[FieldStamp];
          end
        end
      end
      push_o.sum_valid            = 1'b1;
      push_o.sum_res.kind         = KIND_SUM;
      push_o.sum_res.power_on     = sum_p;
      push_o.sum_res.has_fix      = sum_f;
      push_o.sum_res.status       = sum_st;
      push_o.sum_res.last_of_run  = 1'b1;
      if (sum_st == ST_OK && sum_f) begin
        push_o.sum_res.date_digits = st_d.stamp_digits[55:24];
        push_o.sum_res.time_digits = st_d.stamp_digits[23:0];
      end
    end else begin
      push_o.char_res.last_of_run = 1'b1;
    end

    if (!acc_i) begin
      push_o.char_valid = 1'b0;
      push_o.sum_valid  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= line_clear();
      line_done_q <= 1'b0;
    end else if (acc_i) begin
      st_q        <= st_d;
      line_done_q <= end_line;
    end
  end

endmodule
`default_nettype wire

[sv/gilp_result_queue.sv]
`default_nettype none
module gilp_result_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire gilp_pkg::push_t push_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  wire logic            stall_i,
  output gilp_pkg::result_t    res_o
);
  import gilp_pkg::*;

  result_t    mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;
  logic [1:0] n_push;

  assign pop     = valid_o && !stall_i;
  assign valid_o = (cnt_q != 3'd0);
  assign res_o   = mem_q[rd_q];
  assign full_o  = (cnt_q > 3'd2);
  assign n_push  = {1'b0, push_i.char_valid} + {1'b0, push_i.sum_valid};
  assign cnt_d   = cnt_q + {1'b0, n_push} - {2'b0, pop};

  always_ff @(posedge clk_i) begin
    if (push_i.char_valid) begin
      mem_q[wr_q] <= push_i.char_res;
      if (push_i.sum_valid) mem_q[wr_q + 2'd1] <= push_i.sum_res;
    end else if (push_i.sum_valid) begin
      mem_q[wr_q] <= push_i.sum_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + n_push;
      if (pop) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

[sv/gnss_info_line_parser.sv]
// Parses one GNSS info reply line per run of bytes, one byte per clock when not
// stalled. Every item is taken in the cycle it is offered unless the four-entry
// result queue holds more than two results; a byte yields at most two results
// (one coordinate character and the line summary), and in a line of
// single-result bytes the block sustains one item per cycle while out_stall_i
// is low. Results leave the queue one per cycle while out_stall_i is low, the
// cycle after the byte that caused them at the earliest. Summaries follow the
// byte with line_last or a carriage return; the next byte opens a new line.
`default_nettype none
module gnss_info_line_parser #(
  parameter int FIELD_CHARS = 16,
  parameter int MAX_LINE    = 255
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  ch_i,
  input  wire logic        line_last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       text_char_o,
  output logic             power_on_o,
  output logic             has_fix_o,
  output logic [2:0]       status_o,
  output logic [31:0]      date_digits_o,
  output logic [23:0]      time_digits_o,
  output logic             last_of_run_o
);
  import gilp_pkg::*;

  push_t   push;
  result_t res;
  logic    acc;
  logic    full;

  assign in_stall_o = full;
  assign acc        = in_valid_i && !full;

  gilp_parser #(
    .FIELD_CHARS(FIELD_CHARS),
    .MAX_LINE   (MAX_LINE)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .ch_i       (ch_i),
    .line_last_i(line_last_i),
    .push_o     (push)
  );

  gilp_result_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .res_o  (res)
  );

  assign kind_o        = res.kind;
  assign text_char_o   = res.text_char;
  assign power_on_o    = res.power_on;
  assign has_fix_o     = res.has_fix;
  assign status_o      = res.status;
  assign date_digits_o = res.date_digits;
  assign time_digits_o = res.time_digits;
  assign last_of_run_o = res.last_of_run;

endmodule
`default_nettype wire

[sv/gilp_checker.sv]
`default_nettype none
module gilp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  kind_o,
  input wire logic [7:0]  text_char_o,
  input wire logic        power_on_o,
  input wire logic        has_fix_o,
  input wire logic [2:0]  status_o,
  input wire logic [31:0] date_digits_o,
  input wire logic [23:0] time_digits_o
);
  import gilp_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o != 2'd3)
    else $error("bad result kind");

  a_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_SUM |->
      status_o == ST_OK && !power_on_o && !has_fix_o && date_digits_o == '0)
    else $error("character item carries summary fields");

  a_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_SUM && status_o != ST_OK |->
      date_digits_o == '0 && time_digits_o == '0 && text_char_o == '0)
    else $error("timestamp shown on failed line");

  a_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_fix_o |-> power_on_o)
    else $error("fix reported with power off");

endmodule

bind gnss_info_line_parser gilp_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .kind_o       (kind_o),
  .text_char_o  (text_char_o),
  .power_on_o   (power_on_o),
  .has_fix_o    (has_fix_o),
  .status_o     (status_o),
  .date_digits_o(date_digits_o),
  .time_digits_o(time_digits_o)
);
`default_nettype wire

[bench/tb_gnss_info_line_parser.sv]
`default_nettype none
module tb_gnss_info_line_parser;
  import gilp_pkg::*;

  localparam int FieldChars = 16;
  localparam int MaxLine    = 255;
  localparam int RandItems  = 950;
  localparam int IdleLimit  = 3000;
  localparam int EndWait    = 16;
  localparam string PfxText = "+CGNSINF: ";

  typedef enum int {
    SH_GOOD, SH_PWR_OFF, SH_FIX_OFF, SH_PFX_BAD, SH_SHORT, SH_STATUS_BAD, SH_STAMP_BAD,
    SH_COORD_LONG, SH_EXTRA, SH_TRUNC, SH_NUL, SH_OVERLONG, SH_NOISE, SH_COUNT
  } shape_e;

  class line_scoreboard;
    result_t     due[$];
    int          errors;
    int          pfx_cnt;
    bit          pfx_bad;
    int          nbytes;
    bit          cut;
    int          fld;
    int          flen;
    bit          fover;
    cls_e        pwr;
    cls_e        fx;
    logic [55:0] stamp;
    bit          stamp_bad;
    status_e     fcode[Fields];
    bit          done;

    function new();
      errors = 0;
      done = 1'b0;
      clear_line();
    endfunction

    function void clear_line();
      pfx_cnt = 0;
      pfx_bad = 1'b0;
      nbytes = 0;
      cut = 1'b0;
      fld = 0;
      flen = 0;
      fover = 1'b0;
      pwr = CLS_NONE;
      fx = CLS_NONE;
      stamp = '0;
      stamp_bad = 1'b0;
      foreach (fcode[i]) fcode[i] = ST_MISSING;
    endfunction

    function int field_limit();
      return (fld < FieldStamp) ? 2 : FieldChars;
    endfunction

    function cls_e sort_char(logic [7:0] c);
      if (c == ChZero) return CLS_ZERO;
      if (c == ChOne) return CLS_ONE;
      return CLS_OTHER;
    endfunction

    function void close_field(bit term);
      status_e code;
      if (fld > FieldLon) return;
      if (fover) code = ST_LONG;
      else if (!term) code = ST_MISSING;
      else if (flen >= field_limit()) code = ST_LONG;
      else if (fld == FieldPower)
        code = (pwr == CLS_ZERO || pwr == CLS_ONE) ? ST_OK : ST_CHAR;
      else if (fld == FieldFix)
        code = (fx == CLS_ZERO || fx == CLS_ONE) ? ST_OK : ST_CHAR;
      else if (fld == FieldStamp)
        code = (flen < StampLen || stamp_bad) ? ST_STAMP : ST_OK;
      else code = ST_OK;
      fcode[fld] = code;
    endfunction

    // Returns 1 when the byte is parsed or ends a line.
    function bit parse_byte(logic [7:0] c, logic l);
      bit      acc;
      bit      ends;
      bit      have_chr;
      result_t chr;
      result_t sum;
      status_e st;
      if (done) begin
        clear_line();
        done = 1'b0;
      end
      have_chr = 1'b0;
      chr = '0;
      sum = '0;
      acc = !cut && nbytes < MaxLine && c != ChNul;
      if (c == ChNul) cut = 1'b1;
      ends = l || c == ChCr;
      if (acc) begin
        nbytes++;
        if (pfx_cnt < PrefixLen) begin
          if (c != PfxText[pfx_cnt]) pfx_bad = 1'b1;
          pfx_cnt++;
        end else if (!pfx_bad) begin
          if (c == ChComma || c == ChCr) begin
            close_field(1'b1);
            if (c == ChCr) fld = FieldPast;
            else if (fld < FieldPast) fld++;
            flen = 0;
            fover = 1'b0;
          end else if (fld <= FieldLon) begin
            if (flen >= field_limit()) begin
              fover = 1'b1;
            end else if (fld == FieldPower) begin
              if (flen == 0) pwr = sort_char(c);
            end else if (fld == FieldFix) begin
              if (flen == 0) fx = sort_char(c);
            end else if (fld == FieldStamp) begin
              if (flen < StampLen) begin
                if (c >= ChZero && c <= ChNine) stamp = {stamp[51:0], c[3:0]};
                else stamp_bad = 1'b1;
              end
            end else if (fcode[FieldPower] == ST_OK && pwr == CLS_ONE &&
                         fcode[FieldFix] == ST_OK && fx == CLS_ONE &&
                         flen < FieldChars - 1) begin
              have_chr = 1'b1;
              chr.kind = (fld == FieldLat) ? KIND_LAT : KIND_LON;
              chr.text_char = c;
            end
            if (flen < LenMax) flen++;
          end
        end
      end
      if (ends) begin
        st = ST_OK;
        sum.kind = KIND_SUM;
        if (pfx_bad || pfx_cnt < PrefixLen || nbytes <= PrefixLen) begin
          st = ST_PREFIX;
        end else begin
          close_field(1'b0);
          if (fcode[FieldPower] != ST_OK) begin
            st = fcode[FieldPower];
          end else if (pwr == CLS_ONE) begin
            sum.power_on = 1'b1;
            if (fcode[FieldFix] != ST_OK) begin
              st = fcode[FieldFix];
            end else if (fx == CLS_ONE) begin
              sum.has_fix = 1'b1;
              if (fcode[FieldLat] != ST_OK) st = fcode[FieldLat];
              else if (fcode[FieldLon] != ST_OK) st = fcode[FieldLon];
              else st = fcode[FieldStamp];
            end
          end
        end
        sum.status = st;
        if (st == ST_OK && sum.has_fix) begin
          sum.date_digits = stamp[55:24];
          sum.time_digits = stamp[23:0];
        end
        done = 1'b1;
        if (have_chr) due.push_back(chr);
        sum.last_of_run = 1'b1;
        due.push_back(sum);
      end else if (have_chr) begin
        chr.last_of_run = 1'b1;
        due.push_back(chr);
      end
      return acc || ends;
    endfunction

    function void match(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due.size() == 0) begin
        $error("result with none pending: kind %0d status %0d", got.kind, got.status);
        errors++;
        return;
      end
      want = due.pop_front();
      match("kind", want.kind, got.kind);
      match("text_char", want.text_char, got.text_char);
      match("power_on", want.power_on, got.power_on);
      match("has_fix", want.has_fix, got.has_fix);
      match("status", want.status, got.status);
      match("date_digits", want.date_digits, got.date_digits);
      match("time_digits", want.time_digits, got.time_digits);
      match("last_of_run", want.last_of_run, got.last_of_run);
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  ch_i        = '0;
  logic        line_last_i = 1'b0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  kind_o;
  logic [7:0]  text_char_o;
  logic        power_on_o;
  logic        has_fix_o;
  logic [2:0]  status_o;
  logic [31:0] date_digits_o;
  logic [23:0] time_digits_o;
  logic        last_of_run_o;
  result_t     out_res;

  line_scoreboard sb = new();
  logic [7:0]     line_q[$];
  int             burst_left = 0;
  int             parsed_items = 0;
  int             idle_cycles = 0;
  int             stall_pct = 0;
  int             stall_span = 0;

  gnss_info_line_parser #(
    .FIELD_CHARS(FieldChars),
    .MAX_LINE   (MaxLine)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .ch_i         (ch_i),
    .line_last_i  (line_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .text_char_o  (text_char_o),
    .power_on_o   (power_on_o),
    .has_fix_o    (has_fix_o),
    .status_o     (status_o),
    .date_digits_o(date_digits_o),
    .time_digits_o(time_digits_o),
    .last_of_run_o(last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  assign out_res = {kind_o, text_char_o, power_on_o, has_fix_o, status_o,
                    date_digits_o, time_digits_o, last_of_run_o};

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_res);
  end

  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_span = $urandom_range(10, 80);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 50;
        default: stall_pct = 90;
      endcase
    end
    stall_span--;
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_gnss_info_line_parser: done, errors");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] c, logic l);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    ch_i        <= c;
    line_last_i <= l;
    do @(posedge clk_i); while (in_stall_o);
    if (sb.parse_byte(c, l)) parsed_items++;
    burst_left--;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic send_line(bit with_cr, bit with_last);
    if (with_cr || line_q.size() == 0) line_q.push_back(ChCr);
    foreach (line_q[i]) send_byte(line_q[i], with_last && i == line_q.size() - 1);
  endtask

  function automatic logic [7:0] text_byte();
    string      pool;
    logic [7:0] b;
    pool = "0123456789.-NSEW";
    if ($urandom_range(0, 3) != 0) return pool[$urandom_range(0, pool.len() - 1)];
    do b = 8'($urandom_range(1, 255)); while (b == ChCr || b == ChComma);
    return b;
  endfunction

  task automatic put_str(string s);
    foreach (s[i]) line_q.push_back(s[i]);
  endtask

  task automatic put_digits(int n);
    repeat (n) line_q.push_back(ChZero + 8'($urandom_range(0, 9)));
  endtask

  task automatic put_text(int n);
    repeat (n) line_q.push_back(text_byte());
  endtask

  task automatic put_bad_status();
    case ($urandom_range(0, 4))
      0: ;
      1: put_str("2");
      2: put_str("11");
      3: put_str("10");
      default: line_q.push_back(text_byte());
    endcase
  endtask

  task automatic build_line(shape_e sh);
    int         k;
    bit         coin;
    logic [7:0] b;
    line_q.delete();
    coin = $urandom_range(0, 1);
    if (sh == SH_NOISE) begin
      repeat ($urandom_range(1, 30)) line_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (sh == SH_SHORT) begin
      k = $urandom_range(0, PrefixLen);
      for (int i = 0; i < k; i++) line_q.push_back(PfxText[i]);
      return;
    end
    put_str(PfxText);
    if (sh == SH_PFX_BAD) line_q[$urandom_range(0, PrefixLen - 1)] = 8'($urandom_range(1, 255));
    if (sh == SH_PWR_OFF) put_str("0");
    else if (sh == SH_STATUS_BAD && coin) put_bad_status();
    else put_str("1");
    put_str(",");
    if (sh == SH_FIX_OFF) put_str("0");
    else if (sh == SH_STATUS_BAD && !coin) put_bad_status();
    else put_str("1");
    put_str(",");
    if (sh == SH_STAMP_BAD) begin
      k = $urandom_range(0, 13);
      case ($urandom_range(0, 2))
        0: put_digits(k);
        1: begin
          put_digits(k);
          do b = text_byte(); while (b >= ChZero && b <= ChNine);
          line_q.push_back(b);
          put_digits(13 - k);
        end
        default: put_digits($urandom_range(16, 20));
      endcase
    end else begin
      put_digits(14);
      case ($urandom_range(0, 3))
        1: begin
          put_str(".");
          put_digits(3);
        end
        2: put_digits(1);
        default: ;
      endcase
    end
    put_str(",");
    put_text((sh == SH_COORD_LONG && coin) ? $urandom_range(16, 24) : $urandom_range(0, 15));
    put_str(",");
    put_text((sh == SH_COORD_LONG && !coin) ? $urandom_range(16, 24) : $urandom_range(0, 15));
    if (sh == SH_EXTRA || $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        put_str(",");
        put_text($urandom_range(0, 6));
      end
    end
    if (sh == SH_OVERLONG) begin
      k = $urandom_range(256, 300);
      while (line_q.size() < k) begin
        put_str(",");
        put_text($urandom_range(0, 20));
      end
    end
    if (sh == SH_TRUNC) begin
      k = $urandom_range(PrefixLen, line_q.size() - 1);
      while (line_q.size() > k) void'(line_q.pop_back());
    end
    if (sh == SH_NUL) line_q.insert($urandom_range(0, line_q.size()), ChNul);
  endtask

  initial begin
    shape_e sh;
    int     nline;
    int     r;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_byte(8'hff, 1'b1);
    send_byte(ChNul, 1'b1);
    send_byte(ChCr, 1'b0);
    line_q.delete();
    put_str({PfxText, "0"});
    send_line(1'b0, 1'b1);
    line_q.delete();
    put_str(PfxText);
    send_line(1'b1, 1'b0);

    // one line of each shape first, then a mix weighted to well-formed lines
    parsed_items = 0;
    nline = 0;
    while (parsed_items < RandItems) begin
      if (nline < SH_COUNT) begin
        sh = shape_e'(nline);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) sh = SH_GOOD;
        else if (r < 47) sh = SH_OVERLONG;
        else sh = shape_e'($urandom_range(SH_PWR_OFF, SH_NOISE));
        if (sh == SH_OVERLONG && r >= 47) sh = SH_GOOD;
      end
      build_line(sh);
      r = $urandom_range(0, 9);
      if (sh == SH_NOISE || r >= 8) send_line(1'b0, 1'b1);
      else send_line(1'b1, r >= 6);
      if (nline == SH_COUNT || $urandom_range(0, 19) == 0) drain();
      nline++;
    end

    drain();
    repeat (EndWait) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_gnss_info_line_parser: done, clean");
    else
      $display("tb_gnss_info_line_parser: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
